/* rtl/tcbae_pkg.sv */
`default_nettype none

package tcbae_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int IDX_W       = 4;
  localparam int DIST_W      = 18;
  localparam int NODE_COUNT  = 2 * ENTRY_COUNT - 1;
  localparam int LEAF_BASE   = ENTRY_COUNT - 1;

  typedef logic [23:0]       rgb_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [15:0]       sq_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_MANY_COLOURS = 2'd1,
    ERR_BOTH_BRIGHT = 2'd2
  } err_t;

  localparam logic [7:0] CHAR_SOLID = 8'h17;
  localparam logic [7:0] BIT_TL     = 8'h01;
  localparam logic [7:0] BIT_TR     = 8'h02;
  localparam logic [7:0] BIT_BR     = 8'h04;
  localparam logic [7:0] BIT_BL     = 8'h10;

  // Every palette byte is one of these four levels.
  localparam logic [7:0] LEVEL [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

  localparam rgb_t PALETTE [ENTRY_COUNT] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAAAA00, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic [6:0] attribute;
    err_t       error_code;
  } result_t;

  function automatic logic [1:0] level_of(input logic [7:0] b);
    logic [1:0] lv;
    case (b)
      8'h00:   lv = 2'd0;
      8'h55:   lv = 2'd1;
      8'hAA:   lv = 2'd2;
      default: lv = 2'd3;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

/* rtl/tcbae_if.sv */
`default_nettype none

interface tcbae_cell_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_top_left;
  logic [23:0] pixel_top_right;
  logic [23:0] pixel_bottom_right;
  logic [23:0] pixel_bottom_left;

  modport source (output valid, pixel_top_left, pixel_top_right,
                  pixel_bottom_right, pixel_bottom_left, input ready);
  modport sink (input valid, pixel_top_left, pixel_top_right,
                pixel_bottom_right, pixel_bottom_left, output ready);
endinterface

interface tcbae_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [6:0] attribute;
  logic [1:0] error_code;

  modport source (output valid, char_code, attribute, error_code, input ready);
  modport sink (input valid, char_code, attribute, error_code, output ready);
endinterface

`default_nettype wire

/* rtl/tcbae_nearest.sv */
`default_nettype none

module tcbae_nearest
  import tcbae_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 16
) (
  input  rgb_t pixel,
  output idx_t index
);

  sq_t   sq        [3][4];
  dist_t node_dist [NODE_COUNT];
  idx_t  node_idx  [NODE_COUNT];
  logic  node_ok   [NODE_COUNT];

  // Squared distance of each channel byte to each of the four levels.
  always_comb begin
    logic [7:0] b;
    logic [7:0] d;
    for (int ch = 0; ch < 3; ch++) begin
      for (int lv = 0; lv < 4; lv++) begin
        b = pixel[8*ch +: 8];
        d = (b > LEVEL[lv]) ? (b - LEVEL[lv]) : (LEVEL[lv] - b);
        sq[ch][lv] = sq_t'(d) * sq_t'(d);
      end
    end
  end

  // Tournament tree; the left child holds lower indices and wins a tie.
  always_comb begin
    logic take_left;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      node_dist[LEAF_BASE + i] = dist_t'(sq[0][level_of(PALETTE[i][7:0])])
                               + dist_t'(sq[1][level_of(PALETTE[i][15:8])])
                               + dist_t'(sq[2][level_of(PALETTE[i][23:16])]);
      node_idx[LEAF_BASE + i]  = idx_t'(i);
      node_ok[LEAF_BASE + i]   = (i < PALETTE_ENTRIES) || (i == 0);
    end
    for (int n = LEAF_BASE - 1; n >= 0; n--) begin
      take_left = node_ok[2*n+1] &&
                  (!node_ok[2*n+2] || (node_dist[2*n+1] <= node_dist[2*n+2]));
      node_ok[n]   = node_ok[2*n+1] || node_ok[2*n+2];
      node_dist[n] = take_left ? node_dist[2*n+1] : node_dist[2*n+2];
      node_idx[n]  = take_left ? node_idx[2*n+1]  : node_idx[2*n+2];
    end
  end

  assign index = node_idx[0];

endmodule

`default_nettype wire

/* rtl/tcbae_classify.sv */
`default_nettype none

module tcbae_classify
  import tcbae_pkg::*;
(
  input  idx_t    c_tl,
  input  idx_t    c_tr,
  input  idx_t    c_br,
  input  idx_t    c_bl,
  output result_t res
);

  idx_t second;
  idx_t ink;
  idx_t paper;
  logic solid;
  logic many;

  always_comb begin
    // First colour that differs from the top left, scanning in cell order.
    if (c_tr != c_tl) begin
      second = c_tr;
    end else if (c_br != c_tl) begin
      second = c_br;
    end else begin
      second = c_bl;
    end
    solid = (second == c_tl);
    many  = ((c_tr != c_tl) && (c_tr != second)) ||
            ((c_br != c_tl) && (c_br != second)) ||
            ((c_bl != c_tl) && (c_bl != second));
    ink   = (c_tl > second) ? c_tl : second;
    paper = (c_tl > second) ? second : c_tl;
  end

  always_comb begin
    res = '{char_code: '0, attribute: '0, error_code: ERR_NONE};
    if (many) begin
      res.error_code = ERR_MANY_COLOURS;
    end else if (solid) begin
      res.char_code = CHAR_SOLID;
      res.attribute = {ink[3], 3'b000, ink[2:0]};
    end else if (paper[3]) begin
      res.error_code = ERR_BOTH_BRIGHT;
    end else begin
      res.char_code = ((c_tl == ink) ? BIT_TL : 8'h00) |
                      ((c_tr == ink) ? BIT_TR : 8'h00) |
                      ((c_br == ink) ? BIT_BR : 8'h00) |
                      ((c_bl == ink) ? BIT_BL : 8'h00);
      res.attribute = {ink[3], paper[2:0], ink[2:0]};
    end
  end

endmodule

`default_nettype wire

/* rtl/two_color_block_attribute_encoder_top.sv */
`default_nettype none

// Two-colour 2x2 cell encoder. Each cell word carries four 24-bit RGB pixels.
// Every pixel is matched to the nearest of the first PALETTE_ENTRIES colours
// of the fixed 16-colour palette (sum of squared byte differences, lowest
// index on a tie). The cell gives one result word with the block glyph, the
// ink/paper/bright attribute and an error code. One cell is taken every clock
// while results are taken. A cell goes into the input register, then its result
// into the result register. The clock period is set by the palette search: the
// per-channel squares, the three-term sums and a four-level compare tree.
module two_color_block_attribute_encoder_top
  import tcbae_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 16
) (
  input wire logic       clk,
  input wire logic       rst,
  tcbae_cell_if.sink     pixels,
  tcbae_result_if.source result
);

  logic    s1_valid;
  rgb_t    s1_tl;
  rgb_t    s1_tr;
  rgb_t    s1_br;
  rgb_t    s1_bl;
  logic    out_valid;
  result_t out_res;

  idx_t    c_tl;
  idx_t    c_tr;
  idx_t    c_br;
  idx_t    c_bl;
  result_t res_next;
  logic    advance;

  // Move the stage forward when the result register is empty or being drained.
  assign advance      = !out_valid || result.ready;
  assign pixels.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.ready && pixels.valid) begin
      s1_tl <= pixels.pixel_top_left;
      s1_tr <= pixels.pixel_top_right;
      s1_br <= pixels.pixel_bottom_right;
      s1_bl <= pixels.pixel_bottom_left;
    end
  end

  tcbae_nearest #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_near_tl (.pixel(s1_tl), .index(c_tl));
  tcbae_nearest #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_near_tr (.pixel(s1_tr), .index(c_tr));
  tcbae_nearest #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_near_br (.pixel(s1_br), .index(c_br));
  tcbae_nearest #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_near_bl (.pixel(s1_bl), .index(c_bl));

  tcbae_classify u_classify (
    .c_tl (c_tl),
    .c_tr (c_tr),
    .c_br (c_br),
    .c_bl (c_bl),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_res <= res_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.char_code  = out_res.char_code;
  assign result.attribute  = out_res.attribute;
  assign result.error_code = out_res.error_code;

endmodule

`default_nettype wire

/* tb/sv/tb_two_color_block_attribute_encoder_top.sv */
`timescale 1ns / 1ps

module tb_two_color_block_attribute_encoder_top
  import tcbae_pkg::*;
;

  localparam int PAL_N        = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_CELLS  = 250;
  localparam int PRINT_CAP    = 60;

  // Pixel order inside one cell word: [0] top left, [1] top right,
  // [2] bottom right, [3] bottom left.
  typedef logic [3:0][23:0] cell_px_t;

  typedef struct {
    cell_px_t px;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcbae_cell_if   cell_bus ();
  tcbae_result_if result_bus ();

  two_color_block_attribute_encoder_top #(
    .PALETTE_ENTRIES(PAL_N)
  ) u_dut (clk, rst, cell_bus, result_bus);

  result_t   glyph_q [$];
  stim_row_t dir_rows [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        cell_idle_pct = 0;
  int        result_stall_pct = 0;
  result_t   head;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rgb_t palette_colour(input int idx);
    rgb_t c;
    case (idx)
      0:  c = 24'h000000;
      1:  c = 24'h0000AA;
      2:  c = 24'h00AA00;
      3:  c = 24'h00AAAA;
      4:  c = 24'hAA0000;
      5:  c = 24'hAA00AA;
      6:  c = 24'hAAAA00;
      7:  c = 24'hAAAAAA;
      8:  c = 24'h555555;
      9:  c = 24'h5555FF;
      10: c = 24'h55FF55;
      11: c = 24'h55FFFF;
      12: c = 24'hFF5555;
      13: c = 24'hFF55FF;
      14: c = 24'hFFFF55;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic idx_t nearest_colour(input rgb_t px);
    int unsigned best_dist;
    int unsigned sum_sq;
    int          d;
    int          searched;
    rgb_t        p;
    idx_t        best;
    best      = '0;
    best_dist = 32'hFFFF_FFFF;
    searched  = (PAL_N > 16) ? 16 : ((PAL_N < 1) ? 1 : PAL_N);
    for (int i = 0; i < searched; i++) begin
      p      = palette_colour(i);
      sum_sq = 0;
      for (int k = 0; k < 3; k++) begin
        d      = int'(p[8*k +: 8]) - int'(px[8*k +: 8]);
        sum_sq = sum_sq + d * d;
      end
      // strict compare keeps the lowest index on a tie
      if (sum_sq < best_dist) begin
        best_dist = sum_sq;
        best      = idx_t'(i);
      end
    end
    return best;
  endfunction

  function automatic result_t encode_cell(input cell_px_t px);
    idx_t       c [4];
    idx_t       ink;
    idx_t       paper;
    idx_t       t;
    logic [7:0] glyph;
    logic [7:0] bitval [4];
    result_t    r;
    bitval[0] = BIT_TL;
    bitval[1] = BIT_TR;
    bitval[2] = BIT_BR;
    bitval[3] = BIT_BL;
    r = '{8'h00, 7'h00, ERR_NONE};
    for (int i = 0; i < 4; i++) c[i] = nearest_colour(px[i]);
    ink   = c[0];
    paper = c[0];
    if (c[1] != ink) paper = c[1];
    for (int i = 2; i < 4; i++) begin
      if (c[i] != ink) begin
        if (paper != c[0] && paper != c[i]) begin
          r.error_code = ERR_MANY_COLOURS;
          return r;
        end
        paper = c[i];
      end
    end
    glyph = 8'h00;
    if (ink == paper) begin
      paper = '0;
      glyph = CHAR_SOLID;
    end else begin
      if (ink < paper) begin
        t     = ink;
        ink   = paper;
        paper = t;
      end
      if (paper >= 4'd8) begin
        r.error_code = ERR_BOTH_BRIGHT;
        return r;
      end
      for (int i = 0; i < 4; i++)
        if (c[i] == ink) glyph = glyph | bitval[i];
    end
    r.char_code = glyph;
    r.attribute = {ink[3], paper[2:0], ink[2:0]};
    return r;
  endfunction

  function automatic rgb_t near_colour(input int idx, input int spread);
    rgb_t base;
    rgb_t px;
    int   v;
    base = palette_colour(idx);
    for (int k = 0; k < 3; k++) begin
      v = int'(base[8*k +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      px[8*k +: 8] = v[7:0];
    end
    return px;
  endfunction

  function automatic cell_px_t random_cell();
    cell_px_t px;
    int       kind;
    int       spread;
    int       ca;
    int       cb;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       spread = 0;
      1:       spread = 20;
      default: spread = 60;
    endcase
    ca = $urandom_range(0, 15);
    cb = (ca + $urandom_range(1, 15)) % 16;
    for (int i = 0; i < 4; i++) begin
      if (kind < 20)
        px[i] = near_colour(ca, spread);
      else if (kind < 65)
        px[i] = near_colour($urandom_range(0, 1) ? ca : cb, spread);
      else if (kind < 80)
        px[i] = near_colour($urandom_range(0, 15), spread);
      else
        px[i] = rgb_t'($urandom());
    end
    return px;
  endfunction

  function automatic stim_row_t typed_row(input rgb_t tl, input rgb_t tr, input rgb_t br,
                                          input rgb_t bl, input logic [7:0] ch,
                                          input logic [6:0] attr, input err_t err);
    stim_row_t row;
    row.px    = {bl, br, tr, tl};
    row.typed = 1'b1;
    row.want  = '{ch, attr, err};
    return row;
  endfunction

  function automatic stim_row_t open_row(input rgb_t tl, input rgb_t tr, input rgb_t br,
                                         input rgb_t bl);
    stim_row_t row;
    row.px    = {bl, br, tr, tl};
    row.typed = 1'b0;
    row.want  = '{8'h00, 7'h00, ERR_NONE};
    return row;
  endfunction

  task automatic add_row(input stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_cell(input cell_px_t px, input bit typed, input result_t want);
    while ($urandom_range(0, 99) < cell_idle_pct) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cell_bus.valid              <= 1'b1;
    cell_bus.pixel_top_left     <= px[0];
    cell_bus.pixel_top_right    <= px[1];
    cell_bus.pixel_bottom_right <= px[2];
    cell_bus.pixel_bottom_left  <= px[3];
    @(posedge clk);
    while (!cell_bus.ready) @(posedge clk);
    glyph_q.insert(glyph_q.size(), typed ? want : encode_cell(px));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_two_color_block_attribute_encoder_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) result_bus.ready <= ($urandom_range(0, 99) >= result_stall_pct);

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (glyph_q.size() == 0) begin
        report_mismatch("result with nothing pending", result_bus.char_code, 0);
      end else begin
        head = glyph_q.pop_front();
        if (result_bus.char_code !== head.char_code)
          report_mismatch("char_code", result_bus.char_code, head.char_code);
        if (result_bus.attribute !== head.attribute)
          report_mismatch("attribute", result_bus.attribute, head.attribute);
        if (result_bus.error_code !== head.error_code)
          report_mismatch("error_code", result_bus.error_code, head.error_code);
      end
    end
  end

  initial begin
    cell_bus.valid              <= 1'b0;
    cell_bus.pixel_top_left     <= '0;
    cell_bus.pixel_top_right    <= '0;
    cell_bus.pixel_bottom_right <= '0;
    cell_bus.pixel_bottom_left  <= '0;

    add_row(typed_row(24'h000000, 24'h000000, 24'h000000, 24'h000000,
                      8'h17, 7'h00, ERR_NONE));
    add_row(typed_row(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      8'h17, 7'h47, ERR_NONE));
    add_row(typed_row(24'h5555FF, 24'h5555FF, 24'h5555FF, 24'h5555FF,
                      8'h17, 7'h41, ERR_NONE));
    add_row(typed_row(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000,
                      8'h01, 7'h47, ERR_NONE));
    add_row(typed_row(24'h000000, 24'h0000AA, 24'h000000, 24'h000000,
                      8'h02, 7'h01, ERR_NONE));
    add_row(typed_row(24'h000000, 24'h000000, 24'hAA0000, 24'h000000,
                      8'h04, 7'h04, ERR_NONE));
    add_row(typed_row(24'h000000, 24'h000000, 24'h000000, 24'h00AA00,
                      8'h10, 7'h02, ERR_NONE));
    add_row(typed_row(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      8'h16, 7'h47, ERR_NONE));
    add_row(typed_row(24'hFF5555, 24'hAA0000, 24'hAA0000, 24'hAA0000,
                      8'h01, 7'h64, ERR_NONE));
    // grey pair: bright ink over dark paper
    add_row(typed_row(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                      8'h12, 7'h78, ERR_NONE));
    // equal distance to black and dark blue: black wins
    add_row(typed_row(24'h000055, 24'h0000AA, 24'h0000AA, 24'h0000AA,
                      8'h16, 7'h01, ERR_NONE));
    add_row(typed_row(24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
                      8'h00, 7'h00, ERR_MANY_COLOURS));
    // third colour shows up only at bottom left
    add_row(typed_row(24'h000000, 24'h000000, 24'h0000AA, 24'h00AA00,
                      8'h00, 7'h00, ERR_MANY_COLOURS));
    // three bright colours: colour count is checked first
    add_row(typed_row(24'h555555, 24'hFFFFFF, 24'hFF5555, 24'h555555,
                      8'h00, 7'h00, ERR_MANY_COLOURS));
    add_row(typed_row(24'h555555, 24'hFFFFFF, 24'h555555, 24'hFFFFFF,
                      8'h00, 7'h00, ERR_BOTH_BRIGHT));
    add_row(typed_row(24'hFFFF55, 24'h55FF55, 24'h55FF55, 24'hFFFF55,
                      8'h00, 7'h00, ERR_BOTH_BRIGHT));
    add_row(open_row(24'h2A2A2A, 24'h808080, 24'h7F7F7F, 24'hD4D4D4));
    add_row(open_row(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF0000));
    add_row(open_row(24'h123456, 24'h123456, 24'hFEDCBA, 24'hFEDCBA));
    add_row(open_row(24'h7F0080, 24'h80007F, 24'h7F0080, 24'h80007F));
    add_row(open_row(24'hC0C0C0, 24'h404040, 24'hC0C0C0, 24'hC0C0C0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_cell(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin cell_idle_pct = 0;  result_stall_pct = 0;  end
        1: begin cell_idle_pct = 69; result_stall_pct = 0;  end
        2: begin cell_idle_pct = 0;  result_stall_pct = 69; end
        default: begin cell_idle_pct = 26; result_stall_pct = 26; end
      endcase
      for (int n = 0; n < PHASE_CELLS; n++)
        send_cell(random_cell(), 1'b0, '{8'h00, 7'h00, ERR_NONE});
      // hold the sender off until the pipe has drained
      if (phase == 1) begin
        cell_bus.valid <= 1'b0;
        while (glyph_q.size() != 0) @(posedge clk);
      end
    end

    cell_bus.valid <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (glyph_q.size() != 0) report_mismatch("results left pending", glyph_q.size(), 0);

    if (mismatches == 0) begin
      $display("tb_two_color_block_attribute_encoder_top: done, clean");
    end else begin
      $display("tb_two_color_block_attribute_encoder_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcbae_pkg.sv
rtl/tcbae_if.sv
rtl/tcbae_nearest.sv
rtl/tcbae_classify.sv
rtl/two_color_block_attribute_encoder_top.sv
tb/sv/tb_two_color_block_attribute_encoder_top.sv
